@@ sv/checksum_frame_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// checksum_frame_receiver_defines
// Assertion macros for the checksum frame receiver; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
`define CFR_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define CFR_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	`CFR_ASSERT(lbl, ck, rn, (ante) |-> (cons), msg)
`define CFR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	`CFR_ASSERT(lbl, ck, rn, (ante) |=> (cons), msg)
`else
`define CFR_ASSERT(lbl, ck, rn, prop, msg)
`define CFR_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define CFR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

@@ sv/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksum frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 6;
	localparam int LIMIT_W = 6;
	localparam int INDEX_W = 5;
	localparam int SUM_W   = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [BYTE_W-1:0]  START_CHAR  = 8'h23;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	// register index taken from paddr[2]
	localparam logic REG_PAYLOAD_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		STATUS_GOOD,
		STATUS_MISMATCH,
		STATUS_OVER_LIMIT
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   device_id;
		logic [BYTE_W-1:0]   module_id;
		logic [BYTE_W-1:0]   payload_length;
		logic [INDEX_W-1:0]  byte_index;
		logic [BYTE_W-1:0]   payload_byte;
		logic                has_data;
		logic                last;
	} res_t;

endpackage

@@ sv/cfr_ram.sv @@
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cfr_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/cfr_engine.sv @@
// ----------------------------------------------------------------------------
// cfr_engine
// Frame parser with checksum, payload buffer and result drain sequencer.
// ----------------------------------------------------------------------------
module cfr_engine #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cfr_pkg::LIMIT_W-1:0]  limit,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cfr_pkg::BYTE_W-1:0]   in_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cfr_pkg::res_t                out_res
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [6:0] LIMIT_CAP = 7'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_DEVICE,
		PH_MODULE,
		PH_SIZE,
		PH_DATA,
		PH_CSHIGH,
		PH_CSLOW,
		PH_DRAIN_RD,
		PH_DRAIN_WAIT
	} phase_t;

	phase_t                          phase_q;
	logic [cfr_pkg::BYTE_W-1:0]      device_q;
	logic [cfr_pkg::BYTE_W-1:0]      module_q;
	logic [cfr_pkg::BYTE_W-1:0]      size_q;
	logic [cfr_pkg::COUNT_W-1:0]     count_q;
	logic [cfr_pkg::SUM_W-1:0]       sum_q;
	logic [cfr_pkg::BYTE_W-1:0]      high_q;
	logic                            out_valid_q;
	cfr_pkg::res_t                   out_res_q;

	logic                            take;
	logic                            out_free;
	logic                            is_start;
	logic [6:0]                      limit_eff;
	logic [cfr_pkg::COUNT_W-1:0]     count_next;
	logic [cfr_pkg::SUM_W-1:0]       sum_next;
	logic                            wr_en;
	logic                            rd_en;
	logic [cfr_pkg::BYTE_W-1:0]      rd_data;

	always_comb begin
		out_free   = !out_valid_q || out_ready;
		in_ready   = (phase_q != PH_DRAIN_RD) && (phase_q != PH_DRAIN_WAIT) && out_free;
		take       = in_valid && in_ready;
		is_start   = (in_byte == cfr_pkg::START_CHAR);
		limit_eff  = (7'(limit) > LIMIT_CAP) ? LIMIT_CAP : 7'(limit);
		count_next = count_q + 1'b1;
		sum_next   = sum_q + cfr_pkg::SUM_W'(in_byte);
		wr_en      = take && !is_start && (phase_q == PH_DATA);
		rd_en      = (phase_q == PH_DRAIN_RD);
	end

	cfr_ram #(
		.WIDTH (cfr_pkg::BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (in_byte),
		.rd_en   (rd_en),
		.rd_addr (count_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			device_q    <= '0;
			module_q    <= '0;
			size_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && is_start) begin
				phase_q <= PH_DEVICE;
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_DEVICE: begin
						if (take) begin
							device_q <= in_byte;
							sum_q    <= sum_next;
							phase_q  <= PH_MODULE;
						end
					end
					PH_MODULE: begin
						if (take) begin
							module_q <= in_byte;
							sum_q    <= sum_next;
							phase_q  <= PH_SIZE;
						end
					end
					PH_SIZE: begin
						if (take) begin
							size_q  <= in_byte;
							sum_q   <= sum_next;
							count_q <= '0;
							if (in_byte > 8'(limit_eff)) begin
								out_valid_q <= 1'b1;
								out_res_q   <= '{status: cfr_pkg::STATUS_OVER_LIMIT,
									device_id: device_q, module_id: module_q,
									payload_length: in_byte, byte_index: '0,
									payload_byte: '0, has_data: 1'b0, last: 1'b1};
								phase_q <= PH_IDLE;
							end else if (in_byte == '0) begin
								phase_q <= PH_CSHIGH;
							end else begin
								phase_q <= PH_DATA;
							end
						end
					end
					PH_DATA: begin
						if (take) begin
							sum_q   <= sum_next;
							count_q <= count_next;
							if (8'(count_next) >= size_q) begin
								phase_q <= PH_CSHIGH;
							end
						end
					end
					PH_CSHIGH: begin
						if (take) begin
							high_q  <= in_byte;
							phase_q <= PH_CSLOW;
						end
					end
					PH_CSLOW: begin
						if (take) begin
							if ({high_q, in_byte} != sum_q) begin
								out_valid_q <= 1'b1;
								out_res_q   <= '{status: cfr_pkg::STATUS_MISMATCH,
									device_id: device_q, module_id: module_q,
									payload_length: size_q, byte_index: '0,
									payload_byte: '0, has_data: 1'b0, last: 1'b1};
								phase_q <= PH_IDLE;
							end else if (size_q == '0) begin
								out_valid_q <= 1'b1;
								out_res_q   <= '{status: cfr_pkg::STATUS_GOOD,
									device_id: device_q, module_id: module_q,
									payload_length: size_q, byte_index: '0,
									payload_byte: '0, has_data: 1'b0, last: 1'b1};
								phase_q <= PH_IDLE;
							end else begin
								count_q <= '0;
								phase_q <= PH_DRAIN_RD;
							end
						end
					end
					PH_DRAIN_RD: begin
						phase_q <= PH_DRAIN_WAIT;
					end
					PH_DRAIN_WAIT: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_res_q   <= '{status: cfr_pkg::STATUS_GOOD,
								device_id: device_q, module_id: module_q,
								payload_length: size_q,
								byte_index: count_q[cfr_pkg::INDEX_W-1:0],
								payload_byte: rd_data, has_data: 1'b1,
								last: (8'(count_next) == size_q)};
							count_q <= count_next;
							phase_q <= (8'(count_next) == size_q) ? PH_IDLE : PH_DRAIN_RD;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

@@ sv/checksum_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// checksum_frame_receiver
// Results: an error or empty-frame result item is registered on the edge that
// takes its byte; a good frame's first payload item goes through a RAM read
// state and a wait state and is registered once the output is free. Parsing
// takes one byte a cycle while the output is free; a good frame then drains one item per RAM read, input held off.
// Reset: arst_n clears the parser to idle and payload_limit to 32 at once.
// ----------------------------------------------------------------------------
`include "checksum_frame_receiver_defines.svh"

module checksum_frame_receiver #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] device_id, [15:8] module_id, [23:16] payload_length,
	// [28:24] byte_index, [36:29] payload_byte, [39:37] zero
	output logic [39:0]                   m_tdata,
	output logic [2:0]                    m_tuser,  // [1:0] status, [2] has_data
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfr_pkg::ADDR_W-1:0]    paddr,
	input  logic [cfr_pkg::DATA_W-1:0]    pwdata,
	output logic [cfr_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	logic [cfr_pkg::LIMIT_W-1:0] limit_q;
	logic                        cfg_wr;
	cfr_pkg::res_t               res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == cfr_pkg::REG_PAYLOAD_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= cfr_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[cfr_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			cfr_pkg::REG_PAYLOAD_LIMIT: prdata = cfr_pkg::DATA_W'(limit_q);
			default:                    prdata = '0;
		endcase
	end

	cfr_engine #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {3'b000, res.payload_byte, res.byte_index, res.payload_length,
		res.module_id, res.device_id};
	assign m_tuser = {res.has_data, res.status};
	assign m_tlast = res.last;

	`CFR_ASSERT_IMPLY(a_ready_needs_room, clk, arst_n, s_tready, (!m_tvalid || m_tready), "input taken while result blocked")
	`CFR_ASSERT_NEXT(a_start_no_result, clk, arst_n, (s_tvalid && s_tready && (s_tdata == cfr_pkg::START_CHAR)), !$rose(m_tvalid), "start byte produced a result")
	`CFR_ASSERT_IMPLY(a_empty_is_last, clk, arst_n, (m_tvalid && !m_tuser[2]), m_tlast, "dataless result not last")
	`CFR_ASSERT_IMPLY(a_error_no_data, clk, arst_n, (m_tvalid && (m_tuser[1:0] != cfr_pkg::STATUS_GOOD)), !m_tuser[2], "error result carries data")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the checksum frame receiver. Bytes go in on the
// input stream, the payload limit is set over the register port, and every
// result item is compared field by field against a software parser that
// tracks each accepted byte. A short table of hand-built frames comes first,
// then random frames (good, corrupted, oversized, restarted and noise) under
// several limits, with random gaps and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_PAYLOAD   = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [cfr_pkg::ADDR_W-1:0] LIMIT_ADDR = {cfr_pkg::REG_PAYLOAD_LIMIT, 2'b00};

	typedef enum logic [2:0] {
		P_IDLE,
		P_DEVICE,
		P_MODULE,
		P_SIZE,
		P_DATA,
		P_CSHIGH,
		P_CSLOW
	} parse_phase_t;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_SUM,
		FRAME_OVERSIZE,
		FRAME_CUT,
		FRAME_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		cfr_pkg::res_t res;
	} row_t;

	localparam cfr_pkg::res_t NO_RES = '0;

	localparam row_t DIRECTED [27] = '{
		'{8'hFF, 1'b0, NO_RES},
		'{cfr_pkg::START_CHAR, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'hFE, 1'b1, '{cfr_pkg::STATUS_GOOD, 8'hFF, 8'hFF, 8'h00, 5'd0, 8'h00,
			1'b0, 1'b1}},
		'{cfr_pkg::START_CHAR, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'hFF, 1'b1, '{cfr_pkg::STATUS_OVER_LIMIT, 8'h00, 8'h00, 8'hFF, 5'd0, 8'h00,
			1'b0, 1'b1}},
		'{cfr_pkg::START_CHAR, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'h02, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'h80, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b1, '{cfr_pkg::STATUS_MISMATCH, 8'h01, 8'h02, 8'h01, 5'd0, 8'h00,
			1'b0, 1'b1}},
		'{cfr_pkg::START_CHAR, 1'b0, NO_RES},
		'{8'h10, 1'b0, NO_RES},
		'{cfr_pkg::START_CHAR, 1'b0, NO_RES},
		'{8'h05, 1'b0, NO_RES},
		'{8'h06, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'hAA, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'hB6, 1'b0, NO_RES}
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata = '0;     // [7:0] rx_byte
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	// [7:0] device_id, [15:8] module_id, [23:16] payload_length,
	// [28:24] byte_index, [36:29] payload_byte, [39:37] zero
	logic [39:0]                 m_tdata;
	logic [2:0]                  m_tuser;          // [1:0] status, [2] has_data
	logic                        m_tlast;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [cfr_pkg::ADDR_W-1:0]  paddr = '0;
	logic [cfr_pkg::DATA_W-1:0]  pwdata = '0;
	logic [cfr_pkg::DATA_W-1:0]  prdata;
	logic                        pready;

	parse_phase_t                cur_phase = P_IDLE;
	logic [7:0]                  cur_device = '0;
	logic [7:0]                  cur_module = '0;
	logic [7:0]                  cur_size = '0;
	logic [5:0]                  cur_count = '0;
	logic [15:0]                 cur_sum = '0;
	logic [7:0]                  cur_sum_high = '0;
	logic [7:0]                  payload_copy [MAX_PAYLOAD];
	logic [cfr_pkg::LIMIT_W-1:0] cur_limit = cfr_pkg::LIMIT_RESET;

	cfr_pkg::res_t pending_results [$];
	cfr_pkg::res_t fresh_results [$];

	int  fail_count = 0;
	int  cycle_count = 0;
	int  bytes_sent = 0;
	int  frame_bytes = 0;
	int  results_seen = 0;
	int  kind_count [5] = '{0, 0, 0, 0, 0};
	bit  src_steady = 1'b0;
	bit  hold_req = 1'b0;
	bit  holding = 1'b0;

	checksum_frame_receiver #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("checksum_frame_receiver verification failed");
			$finish;
		end
	end

	function automatic cfr_pkg::res_t frame_result(input cfr_pkg::status_t st,
			input logic [4:0] idx, input logic [7:0] data, input logic has,
			input logic lst);
		cfr_pkg::res_t r;
		r.status         = st;
		r.device_id      = cur_device;
		r.module_id      = cur_module;
		r.payload_length = cur_size;
		r.byte_index     = idx;
		r.payload_byte   = data;
		r.has_data       = has;
		r.last           = lst;
		return r;
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b);
		int eff_limit;
		fresh_results.delete();
		if (b == cfr_pkg::START_CHAR) begin
			cur_phase = P_DEVICE;
			cur_count = '0;
			cur_sum   = '0;
			return;
		end
		eff_limit = (cur_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cur_limit);
		case (cur_phase)
			P_DEVICE: begin
				cur_device = b;
				cur_sum += 16'(b);
				cur_phase = P_MODULE;
			end
			P_MODULE: begin
				cur_module = b;
				cur_sum += 16'(b);
				cur_phase = P_SIZE;
			end
			P_SIZE: begin
				cur_size = b;
				cur_sum += 16'(b);
				cur_count = '0;
				if (int'(b) > eff_limit) begin
					fresh_results.push_back(frame_result(cfr_pkg::STATUS_OVER_LIMIT,
						'0, '0, 1'b0, 1'b1));
					cur_phase = P_IDLE;
				end else if (b == 8'd0) begin
					cur_phase = P_CSHIGH;
				end else begin
					cur_phase = P_DATA;
				end
			end
			P_DATA: begin
				if (cur_count < MAX_PAYLOAD)
					payload_copy[cur_count[4:0]] = b;
				cur_sum += 16'(b);
				cur_count = cur_count + 6'd1;
				if (8'(cur_count) >= cur_size)
					cur_phase = P_CSHIGH;
			end
			P_CSHIGH: begin
				cur_sum_high = b;
				cur_phase = P_CSLOW;
			end
			P_CSLOW: begin
				if ({cur_sum_high, b} != cur_sum) begin
					fresh_results.push_back(frame_result(cfr_pkg::STATUS_MISMATCH,
						'0, '0, 1'b0, 1'b1));
				end else if (cur_size == 8'd0) begin
					fresh_results.push_back(frame_result(cfr_pkg::STATUS_GOOD,
						'0, '0, 1'b0, 1'b1));
				end else begin
					for (int i = 0; i < int'(cur_size) && i < MAX_PAYLOAD; i++)
						fresh_results.push_back(frame_result(cfr_pkg::STATUS_GOOD, 5'(i),
							payload_copy[i], 1'b1, (i + 1 == int'(cur_size))));
				end
				cur_phase = P_IDLE;
			end
			default: cur_phase = P_IDLE;
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] v;
		do
			v = 8'($urandom);
		while (v == cfr_pkg::START_CHAR);
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		cfr_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 8'(want.status), 8'(m_tuser[1:0]));
				check_field("device_id", want.device_id, m_tdata[7:0]);
				check_field("module_id", want.module_id, m_tdata[15:8]);
				check_field("payload_length", want.payload_length, m_tdata[23:16]);
				check_field("byte_index", 8'(want.byte_index), 8'(m_tdata[28:24]));
				check_field("payload_byte", want.payload_byte, m_tdata[36:29]);
				check_field("has_data", 8'(want.has_data), 8'(m_tuser[2]));
				check_field("last", 8'(want.last), 8'(m_tlast));
			end
		end
	end

	initial begin
		int idle;
		int steady_left;
		steady_left = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding  = 1'b0;
				hold_req = 1'b0;
			end
			if (steady_left > 0) begin
				steady_left--;
				idle = 0;
			end else begin
				if ($urandom_range(0, 15) == 0)
					steady_left = $urandom_range(20, 60);
				idle = idle_len();
			end
			if (idle > 0) begin
				m_tready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic typed,
			input cfr_pkg::res_t typed_res);
		int gap;
		gap = src_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		parse_rx_byte(b);
		if (typed)
			pending_results.push_back(typed_res);
		else
			foreach (fresh_results[k])
				pending_results.push_back(fresh_results[k]);
		bytes_sent++;
	endtask

	task automatic send_frame(input frame_kind_t kind, input int size);
		logic [7:0]  body [$];
		logic [15:0] sum;
		int          cut;
		src_steady = ($urandom_range(0, 3) == 0);
		kind_count[int'(kind)]++;
		if (kind == FRAME_NOISE) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom), 1'b0, NO_RES);
			return;
		end
		body.push_back(cfr_pkg::START_CHAR);
		body.push_back(body_byte());
		body.push_back(body_byte());
		body.push_back(8'(size));
		if (kind != FRAME_OVERSIZE) begin
			repeat (size)
				body.push_back(body_byte());
			sum = '0;
			for (int k = 1; k < body.size(); k++)
				sum += 16'(body[k]);
			if (kind == FRAME_BAD_SUM)
				sum ^= 16'($urandom_range(1, 65535));
			body.push_back(sum[15:8]);
			body.push_back(sum[7:0]);
		end
		// restart partway, the rest of the frame is parsed as a new one
		if (kind == FRAME_CUT) begin
			cut = $urandom_range(1, body.size() - 1);
			body[cut] = cfr_pkg::START_CHAR;
		end
		foreach (body[k])
			send_byte(body[k], 1'b0, NO_RES);
		frame_bytes += body.size();
	endtask

	task automatic run_phase(input int bytes_wanted);
		int          start;
		int          r;
		int          eff;
		int          size;
		frame_kind_t kind;
		start = frame_bytes;
		while (frame_bytes - start < bytes_wanted) begin
			eff = (cur_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cur_limit);
			r = $urandom_range(0, 99);
			kind = (r < 60) ? FRAME_GOOD : (r < 72) ? FRAME_BAD_SUM :
				(r < 82) ? FRAME_OVERSIZE : (r < 92) ? FRAME_CUT : FRAME_NOISE;
			r = $urandom_range(0, 99);
			if (kind == FRAME_OVERSIZE) begin
				size = (r < 50) ? eff + 1 : $urandom_range(eff + 1, 255);
				if (size == int'(cfr_pkg::START_CHAR))
					size++;
			end else begin
				size = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, (eff < 6) ? eff : 6) :
					$urandom_range(1, eff);
			end
			send_frame(kind, size);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [cfr_pkg::DATA_W-1:0] wdata,
			output logic [cfr_pkg::DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= LIMIT_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [cfr_pkg::LIMIT_W-1:0] value);
		logic [cfr_pkg::DATA_W-1:0] rd;
		wait_drained();
		apb_access(1'b1, cfr_pkg::DATA_W'(value), rd);
		cur_limit = value;
		apb_access(1'b0, '0, rd);
		if (rd[cfr_pkg::LIMIT_W-1:0] !== value) begin
			$error("payload_limit expected %0d got %0d", value, rd[cfr_pkg::LIMIT_W-1:0]);
			fail_count++;
		end
	endtask

	initial begin
		logic [cfr_pkg::DATA_W-1:0] rd;
		foreach (payload_copy[i])
			payload_copy[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, '0, rd);
		if (rd[cfr_pkg::LIMIT_W-1:0] !== cfr_pkg::LIMIT_RESET) begin
			$error("payload_limit expected %0d got %0d", cfr_pkg::LIMIT_RESET,
				rd[cfr_pkg::LIMIT_W-1:0]);
			fail_count++;
		end

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].res);
		run_phase(12);

		set_limit(6'd1);
		run_phase(8);

		set_limit(cfr_pkg::LIMIT_W'($urandom_range(2, 31)));
		run_phase(10);

		// hold the output off while a full frame and more bytes pile up
		set_limit(6'd32);
		hold_req = 1'b1;
		wait (holding);
		send_frame(FRAME_GOOD, MAX_PAYLOAD);
		run_phase(10);

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes under payload limits 32, 1, mid-range and 32; %0d results.",
			bytes_sent, results_seen);
		$display("Frames: %0d good, %0d bad sum, %0d oversize, %0d restarted, %0d noise.",
			kind_count[FRAME_GOOD], kind_count[FRAME_BAD_SUM], kind_count[FRAME_OVERSIZE],
			kind_count[FRAME_CUT], kind_count[FRAME_NOISE]);
		if (fail_count == 0)
			$display("checksum_frame_receiver verification clean");
		else
			$display("checksum_frame_receiver verification failed");
		$finish;
	end

endmodule
